@@ rtl/jlgs_pkg.sv @@
// ----------------------------------------------------------------------------
// jlgs_pkg
// Shared constants, codes and types of the Jacobi Laplace grid solver.
// ----------------------------------------------------------------------------
package jlgs_pkg;

   // Grid geometry and number format (unsigned Q8.FRAC_BITS).
   localparam int MAX_SIDE    = 128;
   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = VALUE_WIDTH - 8;
   localparam int IDX_W       = $clog2(MAX_SIDE);
   localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int CELLS       = MAX_SIDE * MAX_SIDE;

   // Register and field widths.
   localparam int GRID_SIZE_W = 8;
   localparam int COUNT_W     = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Edge ramp divider: numerator is twice the ramp height (20 in fixed point).
   localparam int NUM_W     = VALUE_WIDTH - 2;
   localparam int NUM_CNT_W = $clog2(NUM_W);
   localparam logic [NUM_W-1:0] RISE_NUM = NUM_W'(20) << FRAC_BITS;

   // Edge base values.
   localparam logic [VALUE_WIDTH-1:0] BASE_LOW  = VALUE_WIDTH'(10) << FRAC_BITS;
   localparam logic [VALUE_WIDTH-1:0] BASE_HIGH = VALUE_WIDTH'(20) << FRAC_BITS;

   // Register reset values.
   localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET   = GRID_SIZE_W'(128);
   localparam logic [VALUE_WIDTH-1:0] TOLERANCE_RESET   = VALUE_WIDTH'(17);
   localparam logic [COUNT_W-1:0]     SWEEP_LIMIT_RESET = COUNT_W'(1000000);

   // Request function codes.
   typedef enum logic {
      FUNC_SOLVE = 1'b0,
      FUNC_READ  = 1'b1
   } jlgs_func_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_SIZE   = 2'd0,
      CSR_TOLERANCE   = 2'd1,
      CSR_SWEEP_LIMIT = 2'd2
   } jlgs_csr_type;

   // Control from the sequencer to the edge ramp unit.
   typedef struct packed {
      logic             start;
      logic             advance;
      logic [IDX_W-1:0] last;
   } jlgs_edge_ctl_type;

   // Status from the edge ramp unit.
   typedef struct packed {
      logic                   ready;
      logic [VALUE_WIDTH-1:0] rise;
   } jlgs_edge_sts_type;

endpackage

@@ rtl/jlgs_ram.sv @@
// ----------------------------------------------------------------------------
// jlgs_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module jlgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/jlgs_edge.sv @@
// ----------------------------------------------------------------------------
// jlgs_edge
// Edge ramp generator: one bit-serial division per solve, then the rounded
// ramp value of each successive edge step by quotient/remainder stepping.
// ----------------------------------------------------------------------------
module jlgs_edge (
   input  logic                       clock,
   input  logic                       reset,
   input  jlgs_pkg::jlgs_edge_ctl_type ctl,
   output jlgs_pkg::jlgs_edge_sts_type sts
);
   import jlgs_pkg::*;

   logic                   busy_ff, busy_in;
   logic [NUM_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SIDE_W:0]        rem_ff, rem_in;
   logic [NUM_W-1:0]       quo_ff, quo_in;
   logic [SIDE_W:0]        div_ff, div_in;
   logic [VALUE_WIDTH-1:0] acc_q_ff, acc_q_in;
   logic [SIDE_W:0]        acc_r_ff, acc_r_in;
   logic [SIDE_W+1:0]      trial;
   logic [SIDE_W+1:0]      sum_r;

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      acc_q_in = acc_q_ff;
      acc_r_in = acc_r_ff;
      trial    = {rem_ff, RISE_NUM[cnt_ff]};
      sum_r    = {1'b0, acc_r_ff} + {1'b0, rem_ff};

      if (ctl.start) begin
         // Divisor is twice the last index; ramp offset starts at half of it.
         busy_in  = 1'b1;
         cnt_in   = NUM_CNT_W'(NUM_W - 1);
         rem_in   = '0;
         quo_in   = '0;
         div_in   = (SIDE_W + 1)'({ctl.last, 1'b0});
         acc_q_in = '0;
         acc_r_in = (SIDE_W + 1)'(ctl.last);
      end else if (busy_ff) begin
         // Restoring division, one numerator bit per cycle.
         if (trial >= {1'b0, div_ff}) begin
            rem_in = (SIDE_W + 1)'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = (SIDE_W + 1)'(trial);
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end else if (ctl.advance) begin
         // Add the step quotient; carry one when the remainder wraps.
         if (sum_r >= {1'b0, div_ff}) begin
            acc_r_in = (SIDE_W + 1)'(sum_r - {1'b0, div_ff});
            acc_q_in = acc_q_ff + VALUE_WIDTH'(quo_ff) + 1'b1;
         end else begin
            acc_r_in = (SIDE_W + 1)'(sum_r);
            acc_q_in = acc_q_ff + VALUE_WIDTH'(quo_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      acc_q_ff <= acc_q_in;
      acc_r_ff <= acc_r_in;
   end

   assign sts.ready = ~busy_ff;
   assign sts.rise  = acc_q_ff;

endmodule

@@ rtl/jacobi_laplace_grid_solver.sv @@
// ----------------------------------------------------------------------------
// jacobi_laplace_grid_solver
// Jacobi solver for the Laplace equation on a square grid, 5-point stencil.
// ----------------------------------------------------------------------------
// A read request returns one cell of the current grid. A solve request on
// an n by n grid clears the interior, lays down the edges (overlapping the
// ramp divide) and then runs sweeps: each interior cell reads its neighbors
// and old value through the current grid's single read port before its new
// value is written, and a copy pass moves the new interior back. The number
// of sweeps depends on the data, tolerance and sweep limit. Only one request
// is in work at a time; a finished result waits in the output register.
module jacobi_laplace_grid_solver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [jlgs_pkg::IDX_W-1:0]          req_row,
   input  logic [jlgs_pkg::IDX_W-1:0]          req_col,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [jlgs_pkg::VALUE_WIDTH-1:0]    rsp_cell_value,
   output logic [jlgs_pkg::COUNT_W-1:0]        rsp_sweeps_done,
   output logic [jlgs_pkg::VALUE_WIDTH-1:0]    rsp_last_error,
   output logic                                rsp_converged,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [jlgs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [jlgs_pkg::CSR_DATA_W-1:0]     csr_data
);
   import jlgs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_ZERO,
      ST_EDGE,
      ST_SWEEP,
      ST_COPY,
      ST_CHECK,
      ST_DONE
   } state_type;

   // Configuration registers.
   logic [GRID_SIZE_W-1:0] grid_size_ff;
   logic [VALUE_WIDTH-1:0] tolerance_ff;
   logic [COUNT_W-1:0]     sweep_limit_ff;

   // Sequencer state and datapath registers.
   state_type              state_ff, state_in;
   logic [SIDE_W-1:0]      side_ff, side_in;
   logic [IDX_W-1:0]       r_ff, r_in;
   logic [IDX_W-1:0]       c_ff, c_in;
   logic [2:0]             step_ff, step_in;
   logic [VALUE_WIDTH+1:0] sum_ff, sum_in;
   logic [VALUE_WIDTH-1:0] old_ff, old_in;
   logic [VALUE_WIDTH-1:0] new_ff, new_in;
   logic [VALUE_WIDTH-1:0] diff_ff, diff_in;
   logic                   diff_vld_ff, diff_vld_in;
   logic [VALUE_WIDTH-1:0] worst_ff, worst_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     sweeps_ff, sweeps_in;
   logic [VALUE_WIDTH-1:0] err_ff, err_in;
   logic                   conv_ff, conv_in;
   logic [VALUE_WIDTH-1:0] cell_ff, cell_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_cell_ff, rsp_cell_in;
   logic [COUNT_W-1:0]     rsp_sweeps_ff, rsp_sweeps_in;
   logic [VALUE_WIDTH-1:0] rsp_err_ff, rsp_err_in;
   logic                   rsp_conv_ff, rsp_conv_in;

   // Memory ports.
   logic                   cur_wr_en, nxt_wr_en;
   logic [ADDR_W-1:0]      cur_wr_addr, nxt_wr_addr, cur_rd_addr, nxt_rd_addr;
   logic [VALUE_WIDTH-1:0] cur_wr_data, nxt_wr_data, cur_rd_data, nxt_rd_data;

   jlgs_edge_ctl_type      edge_ctl;
   jlgs_edge_sts_type      edge_sts;

   logic [SIDE_W-1:0]      side_act;
   logic [IDX_W-1:0]       last_idx;
   logic [IDX_W-1:0]       inner_idx;
   logic [COUNT_W-1:0]     next_count;
   logic [VALUE_WIDTH+1:0] add_a;
   logic                   in_range;
   logic [ADDR_W-1:0]      edge_addr;
   logic [VALUE_WIDTH-1:0] edge_data;

   // Side length in use, held inside the supported range.
   always_comb begin
      if (32'(grid_size_ff) > MAX_SIDE) begin
         side_act = SIDE_W'(MAX_SIDE);
      end else if (32'(grid_size_ff) < 3) begin
         side_act = SIDE_W'(3);
      end else begin
         side_act = SIDE_W'(grid_size_ff);
      end
   end

   assign last_idx   = IDX_W'(side_ff - 1'b1);
   assign inner_idx  = IDX_W'(side_ff - 2'd2);
   assign next_count = count_ff + 1'b1;
   assign in_range   = (32'(req_row) < 32'(side_act)) && (32'(req_col) < 32'(side_act));
   assign add_a      = (step_ff == 3'd1) ? '0 : sum_ff;

   // Address and value of the edge cell written in this step.
   always_comb begin
      case (step_ff)
         3'd0: begin
            edge_addr = {IDX_W'(0), r_ff};
            edge_data = BASE_LOW + edge_sts.rise;
         end
         3'd1: begin
            edge_addr = {r_ff, IDX_W'(0)};
            edge_data = BASE_LOW + edge_sts.rise;
         end
         3'd2: begin
            edge_addr = {r_ff, last_idx};
            edge_data = BASE_HIGH + edge_sts.rise;
         end
         default: begin
            edge_addr = {last_idx, r_ff};
            edge_data = BASE_HIGH + edge_sts.rise;
         end
      endcase
   end

   // Sequencer next-state and datapath logic.
   always_comb begin
      state_in      = state_ff;
      side_in       = side_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      step_in       = step_ff;
      sum_in        = sum_ff;
      old_in        = old_ff;
      new_in        = new_ff;
      diff_in       = diff_ff;
      diff_vld_in   = 1'b0;
      worst_in      = worst_ff;
      count_in      = count_ff;
      sweeps_in     = sweeps_ff;
      err_in        = err_ff;
      conv_in       = conv_ff;
      cell_in       = cell_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_sweeps_in = rsp_sweeps_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_conv_in   = rsp_conv_ff;

      cur_wr_en   = 1'b0;
      cur_wr_addr = {r_ff, c_ff};
      cur_wr_data = '0;
      nxt_wr_en   = 1'b0;
      nxt_wr_addr = {r_ff, c_ff};
      nxt_wr_data = '0;
      cur_rd_addr = {r_ff, c_ff};
      nxt_rd_addr = {r_ff, c_ff};

      edge_ctl.start   = 1'b0;
      edge_ctl.advance = 1'b0;
      edge_ctl.last    = IDX_W'(side_act - 1'b1);

      // Track the largest change of the running sweep.
      if (diff_vld_ff && (diff_ff > worst_ff)) begin
         worst_in = diff_ff;
      end

      // A taken response leaves the output register.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            cur_rd_addr = {req_row, req_col};
            if (req_valid) begin
               cell_in = '0;
               if (req_func == FUNC_READ) begin
                  state_in = in_range ? ST_RD_WAIT : ST_DONE;
               end else begin
                  side_in        = side_act;
                  r_in           = IDX_W'(1);
                  c_in           = IDX_W'(1);
                  edge_ctl.start = 1'b1;
                  state_in       = ST_ZERO;
               end
            end
         end

         ST_RD_WAIT: begin
            cell_in  = cur_rd_data;
            state_in = ST_DONE;
         end

         // Clear the interior of both grids.
         ST_ZERO: begin
            cur_wr_en = 1'b1;
            nxt_wr_en = 1'b1;
            if (c_ff == inner_idx) begin
               c_in = IDX_W'(1);
               if (r_ff == inner_idx) begin
                  r_in     = '0;
                  step_in  = '0;
                  state_in = ST_EDGE;
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end else begin
               c_in = c_ff + 1'b1;
            end
         end

         // Write the edge cells of ramp step r, one per side, into both grids.
         ST_EDGE: begin
            if (edge_sts.ready) begin
               cur_wr_en   = 1'b1;
               nxt_wr_en   = 1'b1;
               cur_wr_addr = edge_addr;
               nxt_wr_addr = edge_addr;
               cur_wr_data = edge_data;
               nxt_wr_data = edge_data;
               if (step_ff == 3'd3) begin
                  edge_ctl.advance = 1'b1;
                  step_in          = '0;
                  if (r_ff == last_idx) begin
                     r_in     = IDX_W'(1);
                     c_in     = IDX_W'(1);
                     count_in = '0;
                     worst_in = '0;
                     state_in = ST_SWEEP;
                  end else begin
                     r_in = r_ff + 1'b1;
                  end
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end

         // One cell of a sweep: read four neighbors and the old value,
         // average, write the new grid and measure the change.
         ST_SWEEP: begin
            case (step_ff)
               3'd0:    cur_rd_addr = {r_ff, c_ff - 1'b1};
               3'd1:    cur_rd_addr = {r_ff, c_ff + 1'b1};
               3'd2:    cur_rd_addr = {r_ff - 1'b1, c_ff};
               3'd3:    cur_rd_addr = {r_ff + 1'b1, c_ff};
               default: cur_rd_addr = {r_ff, c_ff};
            endcase
            if ((step_ff >= 3'd1) && (step_ff <= 3'd4)) begin
               sum_in = add_a + (VALUE_WIDTH + 2)'(cur_rd_data);
            end
            if (step_ff == 3'd5) begin
               old_in = cur_rd_data;
               new_in = sum_ff[VALUE_WIDTH+1:2];
            end
            if (step_ff == 3'd6) begin
               diff_in     = (new_ff >= old_ff) ? (new_ff - old_ff) : (old_ff - new_ff);
               diff_vld_in = 1'b1;
               nxt_wr_en   = 1'b1;
               nxt_wr_data = new_ff;
               step_in     = '0;
               if (c_ff == inner_idx) begin
                  c_in = IDX_W'(1);
                  if (r_ff == inner_idx) begin
                     r_in     = IDX_W'(1);
                     state_in = ST_COPY;
                  end else begin
                     r_in = r_ff + 1'b1;
                  end
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         // Copy the new interior back into the current grid.
         ST_COPY: begin
            if (step_ff == 3'd0) begin
               step_in = 3'd1;
            end else begin
               cur_wr_en   = 1'b1;
               cur_wr_data = nxt_rd_data;
               step_in     = '0;
               if (c_ff == inner_idx) begin
                  c_in = IDX_W'(1);
                  if (r_ff == inner_idx) begin
                     r_in     = IDX_W'(1);
                     state_in = ST_CHECK;
                  end else begin
                     r_in = r_ff + 1'b1;
                  end
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end
         end

         // Decide between another sweep and the end of the solve.
         ST_CHECK: begin
            if ((next_count < sweep_limit_ff) && (worst_ff > tolerance_ff)) begin
               count_in = next_count;
               worst_in = '0;
               step_in  = '0;
               state_in = ST_SWEEP;
            end else begin
               sweeps_in = next_count;
               err_in    = worst_ff;
               conv_in   = (worst_ff <= tolerance_ff);
               state_in  = ST_DONE;
            end
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_cell_in   = cell_ff;
               rsp_sweeps_in = sweeps_ff;
               rsp_err_in    = err_ff;
               rsp_conv_in   = conv_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, status and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sweeps_ff    <= '0;
         err_ff       <= '0;
         conv_ff      <= 1'b0;
         diff_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sweeps_ff    <= sweeps_in;
         err_ff       <= err_in;
         conv_ff      <= conv_in;
         diff_vld_ff  <= diff_vld_in;
      end
      side_ff       <= side_in;
      r_ff          <= r_in;
      c_ff          <= c_in;
      step_ff       <= step_in;
      sum_ff        <= sum_in;
      old_ff        <= old_in;
      new_ff        <= new_in;
      diff_ff       <= diff_in;
      worst_ff      <= worst_in;
      count_ff      <= count_in;
      cell_ff       <= cell_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_sweeps_ff <= rsp_sweeps_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_conv_ff   <= rsp_conv_in;
   end

   // Configuration registers; writes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff   <= GRID_SIZE_RESET;
         tolerance_ff   <= TOLERANCE_RESET;
         sweep_limit_ff <= SWEEP_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_SIZE:   grid_size_ff   <= csr_data[GRID_SIZE_W-1:0];
            CSR_TOLERANCE:   tolerance_ff   <= csr_data[VALUE_WIDTH-1:0];
            CSR_SWEEP_LIMIT: sweep_limit_ff <= csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   jlgs_edge u_edge (
      .clock (clock),
      .reset (reset),
      .ctl   (edge_ctl),
      .sts   (edge_sts)
   );

   jlgs_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CELLS)
   ) u_cur_ram (
      .clock   (clock),
      .wr_en   (cur_wr_en),
      .wr_addr (cur_wr_addr),
      .wr_data (cur_wr_data),
      .rd_en   (1'b1),
      .rd_addr (cur_rd_addr),
      .rd_data (cur_rd_data)
   );

   jlgs_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CELLS)
   ) u_nxt_ram (
      .clock   (clock),
      .wr_en   (nxt_wr_en),
      .wr_addr (nxt_wr_addr),
      .wr_data (nxt_wr_data),
      .rd_en   (1'b1),
      .rd_addr (nxt_rd_addr),
      .rd_data (nxt_rd_data)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_value  = rsp_cell_ff;
   assign rsp_sweeps_done = rsp_sweeps_ff;
   assign rsp_last_error  = rsp_err_ff;
   assign rsp_converged   = rsp_conv_ff;

endmodule

@@ rtl/jlgs_check.sv @@
// ----------------------------------------------------------------------------
// jlgs_check
// Port-level checks of the grid solver, bound to the top level.
// ----------------------------------------------------------------------------
module jlgs_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [jlgs_pkg::VALUE_WIDTH-1:0]    rsp_cell_value,
   input logic [jlgs_pkg::COUNT_W-1:0]        rsp_sweeps_done,
   input logic                                rsp_converged
);
   import jlgs_pkg::*;

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_value))
      else $error("stalled response changed");

   // An accepted request makes the block busy on the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while block stayed free");

   // A converged report always carries a sweep count of at least one.
   a_conv_sweeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_converged |-> rsp_sweeps_done != '0)
      else $error("converged reported with no sweeps");

   // A new response appears only after the block was busy.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a request in work");

endmodule

bind jacobi_laplace_grid_solver jlgs_check u_check (.*);
